@@ src/pjtt_pkg.sv @@
// Shared types, constants and codes for the periodic job timer table.
`default_nettype none

package pjtt_pkg;

    // Table size and derived widths.
    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Field widths.
    localparam int PERIOD_W = 23;
    localparam int TARGET_W = 24;
    localparam int PHASE_W = 9;
    localparam int TICKS_PER_SECOND = 500;
    localparam int MS_PER_TICK = 2;

    // Input kinds carried in s_tuser.
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_SCHED = 2'd1;
    localparam logic [1:0] KIND_CANCEL = 2'd2;

    // Result kinds carried in m_tuser.
    typedef enum logic [2:0] {
        RK_FIRE        = 3'd0,
        RK_TICK_DONE   = 3'd1,
        RK_SCHEDULED   = 3'd2,
        RK_REJECTED    = 3'd3,
        RK_CANCEL_DONE = 3'd4
    } result_kind_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_CANCEL,
        ST_STATUS
    } state_t;

    // One table entry.
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] countdown;
        logic signed [15:0]  repeat_cnt;
        logic [7:0]          job;
        logic [15:0]         context_tag;
        logic [3:0]          priority_val;
    } entry_t;

    // Table operations.
    typedef enum logic [2:0] {
        TOP_NONE,
        TOP_APPEND,
        TOP_UPDATE,
        TOP_CLEAR_REP,
        TOP_REMOVE
    } tbl_op_t;

    // Command from the sequencer to the table.
    typedef struct packed {
        tbl_op_t          op;
        logic [IDX_W-1:0] idx;
        entry_t           wr;
    } tbl_cmd_t;

    // Outcome of the shared entry unit.
    typedef struct packed {
        logic                rep_zero;
        logic                fires;
        logic [PERIOD_W-1:0] cd_next;
        logic signed [15:0]  rep_next;
        logic                cancel_hit;
    } alu_res_t;

endpackage

`default_nettype wire

@@ src/periodic_job_timer_table.sv @@
// Schedule and reject go straight to the status state after acceptance; cancel and
// tick first walk every table entry, then emit their status result.
// Throughput: one item at a time, the table walk steps one entry per cycle
// through the shared entry unit; a stalled output stalls the tick walk when an entry fires.
// Reset (aresetn low, synchronous): empties the table, clears the counters and
// the output valid flag; entry contents are left as they are.
`default_nettype none

module periodic_job_timer_table (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write: start_seconds.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // interval_ms[23:0], repeat_count[39:24], job_id[47:40], context_tag[63:48],
    // priority_req[67:64], cancel_seconds[82:68], zero padding above.
    input  logic [87:0] s_tdata,
    // kind[1:0].
    input  logic [1:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // fired_job[7:0], fired_context[23:8], fired_priority[27:24],
    // seconds_now[59:28], millis_now[91:60], zero padding above.
    output logic [95:0] m_tdata,
    // result_kind[2:0].
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);
    import pjtt_pkg::*;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [TARGET_W-1:0]  target_reg, target_next;
    logic [7:0]           job_reg, job_next;
    result_kind_t         status_reg, status_next;
    logic [PHASE_W-1:0]   phase_reg, phase_next;
    logic [31:0]          sec_reg, sec_next;
    logic [31:0]          ms_reg, ms_next;

    logic                 m_valid_reg, m_valid_next;
    result_kind_t         m_kind_reg;
    logic [7:0]           m_job_reg;
    logic [15:0]          m_ctx_reg;
    logic [3:0]           m_pri_reg;
    logic [31:0]          m_sec_reg;
    logic [31:0]          m_ms_reg;
    logic                 m_last_reg;

    tbl_cmd_t             cmd;
    entry_t               rd_entry;
    logic [CNT_W-1:0]     count;
    alu_res_t             alu;

    logic                 s_accept;
    logic                 out_free;
    logic                 ld_fire;
    logic                 ld_status;
    logic [TARGET_W-1:0]  target_full;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free = !m_valid_reg || m_tready;
    assign target_full = TARGET_W'(s_tdata[82:68]) * TARGET_W'(TICKS_PER_SECOND);

    pjtt_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_idx   (k_reg[IDX_W-1:0]),
        .rd_entry (rd_entry),
        .count    (count)
    );

    pjtt_alu u_alu (
        .ent    (rd_entry),
        .target (target_reg),
        .job    (job_reg),
        .res    (alu)
    );

    // State and request registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            sec_reg <= '0;
            ms_reg <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            sec_reg <= sec_next;
            ms_reg <= ms_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
        target_reg <= target_next;
        job_reg <= job_next;
        status_reg <= status_next;
    end

    // Sequencer: accept, walk the table one entry per cycle (fires wait for output), emit status.
    always_comb begin
        state_next = state_reg;
        k_next = k_reg;
        target_next = target_reg;
        job_next = job_reg;
        status_next = status_reg;
        phase_next = phase_reg;
        sec_next = sec_reg;
        ms_next = ms_reg;
        cmd.op = TOP_NONE;
        cmd.idx = k_reg[IDX_W-1:0];
        cmd.wr = rd_entry;
        ld_fire = 1'b0;
        ld_status = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    k_next = '0;
                    job_next = s_tdata[47:40];
                    target_next = target_full;
                    case (s_tuser)
                        KIND_TICK: begin
                            ms_next = ms_reg + 32'(MS_PER_TICK);
                            if (phase_reg == PHASE_W'(TICKS_PER_SECOND - 1)) begin
                                phase_next = '0;
                                sec_next = sec_reg + 32'd1;
                            end else begin
                                phase_next = phase_reg + PHASE_W'(1);
                            end
                            status_next = RK_TICK_DONE;
                            state_next = ST_TICK;
                        end
                        KIND_SCHED: begin
                            if (count >= CNT_W'(TABLE_DEPTH)) begin
                                status_next = RK_REJECTED;
                            end else begin
                                status_next = RK_SCHEDULED;
                                cmd.op = TOP_APPEND;
                                cmd.idx = count[IDX_W-1:0];
                                cmd.wr.period = s_tdata[23:1];
                                cmd.wr.countdown = s_tdata[23:1];
                                cmd.wr.repeat_cnt = s_tdata[39:24];
                                cmd.wr.job = s_tdata[47:40];
                                cmd.wr.context_tag = s_tdata[63:48];
                                cmd.wr.priority_val = s_tdata[67:64];
                            end
                            state_next = ST_STATUS;
                        end
                        KIND_CANCEL: begin
                            status_next = RK_CANCEL_DONE;
                            state_next = ST_CANCEL;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TICK: begin
                if (k_reg < count) begin
                    if (alu.rep_zero) begin
                        cmd.op = TOP_REMOVE;
                    end else if (!alu.fires || out_free) begin
                        cmd.op = TOP_UPDATE;
                        cmd.wr.countdown = alu.cd_next;
                        cmd.wr.repeat_cnt = alu.rep_next;
                        ld_fire = alu.fires;
                        k_next = k_reg + CNT_W'(1);
                    end
                end else if (out_free) begin
                    ld_status = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CANCEL: begin
                if (k_reg < count) begin
                    if (alu.cancel_hit) begin
                        cmd.op = TOP_CLEAR_REP;
                    end
                    k_next = k_reg + CNT_W'(1);
                end else if (out_free) begin
                    ld_status = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    ld_status = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A configuration transaction loads the seconds counter.
        if (cfg_valid && cfg_ready) begin
            sec_next = cfg_data;
        end
    end

    // Output register valid flag.
    always_comb begin
        if (ld_fire || ld_status) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload: fire results carry the entry, status results carry zeros in the entry fields.
    always_ff @(posedge aclk) begin
        if (ld_fire) begin
            m_kind_reg <= RK_FIRE;
            m_job_reg <= rd_entry.job;
            m_ctx_reg <= rd_entry.context_tag;
            m_pri_reg <= rd_entry.priority_val;
            m_sec_reg <= sec_reg;
            m_ms_reg <= ms_reg;
            m_last_reg <= 1'b0;
        end else if (ld_status) begin
            m_kind_reg <= status_reg;
            m_job_reg <= '0;
            m_ctx_reg <= '0;
            m_pri_reg <= '0;
            m_sec_reg <= sec_reg;
            m_ms_reg <= ms_reg;
            m_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = {4'd0, m_ms_reg, m_sec_reg, m_pri_reg, m_ctx_reg, m_job_reg};
    assign m_tuser = m_kind_reg;
    assign m_tlast = m_last_reg;

endmodule

`default_nettype wire

@@ src/pjtt_alu.sv @@
// Shared entry unit: countdown step, firing test and cancel match for one entry.
`default_nettype none

module pjtt_alu (
    input  pjtt_pkg::entry_t                  ent,
    input  logic [pjtt_pkg::TARGET_W-1:0]     target,
    input  logic [7:0]                        job,
    output pjtt_pkg::alu_res_t                res
);
    import pjtt_pkg::*;

    logic [PERIOD_W-1:0] cd_dec;

    // Countdown decrement wraps at the field width.
    assign cd_dec = ent.countdown - PERIOD_W'(1);

    // Firing reloads the period and consumes one positive repeat.
    always_comb begin
        res.rep_zero = (ent.repeat_cnt == 16'sd0);
        res.fires = (cd_dec == '0);
        res.cd_next = res.fires ? ent.period : cd_dec;
        if (res.fires && (ent.repeat_cnt > 16'sd0)) begin
            res.rep_next = ent.repeat_cnt - 16'sd1;
        end else begin
            res.rep_next = ent.repeat_cnt;
        end
        res.cancel_hit = ({1'b0, ent.period} == target) && (ent.job == job);
    end

endmodule

`default_nettype wire

@@ src/pjtt_table.sv @@
// Ordered entry table with append, update, cancel and close-up removal.
`default_nettype none

module pjtt_table (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pjtt_pkg::tbl_cmd_t             cmd,
    input  logic [pjtt_pkg::IDX_W-1:0]     rd_idx,
    output pjtt_pkg::entry_t               rd_entry,
    output logic [pjtt_pkg::CNT_W-1:0]     count
);
    import pjtt_pkg::*;

    entry_t           ent_reg [TABLE_DEPTH];
    logic [CNT_W-1:0] count_reg;

    // Entry count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            case (cmd.op)
                TOP_APPEND: count_reg <= count_reg + CNT_W'(1);
                TOP_REMOVE: count_reg <= count_reg - CNT_W'(1);
                default:    count_reg <= count_reg;
            endcase
        end
    end

    // Entry storage; removal moves every later entry down by one slot.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            case (cmd.op)
                TOP_APPEND: begin
                    if (cmd.idx == IDX_W'(i)) begin
                        ent_reg[i] <= cmd.wr;
                    end
                end
                TOP_UPDATE: begin
                    if (cmd.idx == IDX_W'(i)) begin
                        ent_reg[i].countdown <= cmd.wr.countdown;
                        ent_reg[i].repeat_cnt <= cmd.wr.repeat_cnt;
                    end
                end
                TOP_CLEAR_REP: begin
                    if (cmd.idx == IDX_W'(i)) begin
                        ent_reg[i].repeat_cnt <= 16'sd0;
                    end
                end
                TOP_REMOVE: begin
                    if ((i < TABLE_DEPTH - 1) && (IDX_W'(i) >= cmd.idx)) begin
                        ent_reg[i] <= ent_reg[(i < TABLE_DEPTH - 1) ? i + 1 : i];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign rd_entry = ent_reg[rd_idx];
    assign count = count_reg;

endmodule

`default_nettype wire

@@ src/pjtt_checker.sv @@
// Port-level checks for the periodic job timer table, bound to the top level.
`default_nettype none

module pjtt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [95:0] m_tdata,
    input wire logic [2:0]  m_tuser,
    input wire logic        m_tlast
);
    import pjtt_pkg::*;

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // Reset empties the output register.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Only status results close a run, and they carry no fired entry.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser != RK_FIRE)))
        else $error("last flag does not match result kind");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata[27:0] == 28'd0))
        else $error("status result carries entry fields");

    // A tick starts a table walk, so the input is not ready in the next cycle.
    a_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_TICK) |=> !s_tready)
        else $error("input ready during a tick walk");

endmodule

bind periodic_job_timer_table pjtt_checker u_pjtt_checker (.*);

`default_nettype wire

@@ tb/periodic_job_timer_table_test.sv @@
// Self-checking testbench for the periodic job timer table: directed and random stimulus.
`timescale 1ns / 100ps

module periodic_job_timer_table_test;
    import pjtt_pkg::*;

    // Kind code that the block ignores.
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 40;

    // One request, with an optional typed-in answer for directed rows.
    typedef struct {
        logic [1:0]         kind;
        logic [23:0]        interval_ms;
        logic signed [15:0] repeat_count;
        logic [7:0]         job_id;
        logic [15:0]        context_tag;
        logic [3:0]         priority_req;
        logic [14:0]        cancel_seconds;
        bit                 fixed_answer;
        result_kind_t       answer_kind;
        logic [31:0]        answer_seconds;
        logic [31:0]        answer_millis;
    } timer_request_t;

    // One result as seen on the output stream.
    typedef struct {
        result_kind_t kind;
        logic [7:0]   job;
        logic [15:0]  tag;
        logic [3:0]   prio;
        logic [31:0]  seconds;
        logic [31:0]  millis;
        logic         last;
    } timer_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // interval_ms, repeat_count, job_id, context_tag, priority_req, cancel_seconds.
    logic [87:0] s_tdata = '0;
    // kind.
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // fired_job, fired_context, fired_priority, seconds_now, millis_now.
    logic [95:0] m_tdata;
    // result_kind.
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // Shadow copy of the job table and the clock.
    logic [PERIOD_W-1:0] job_period [TABLE_DEPTH];
    logic [PERIOD_W-1:0] job_countdown [TABLE_DEPTH];
    logic signed [15:0]  job_repeats [TABLE_DEPTH];
    logic [7:0]          job_ids [TABLE_DEPTH];
    logic [15:0]         job_tags [TABLE_DEPTH];
    logic [3:0]          job_prios [TABLE_DEPTH];
    int                  job_count = 0;
    int                  phase_ticks = 0;
    logic [31:0]         model_seconds = '0;
    logic [31:0]         model_millis = '0;
    int                  tick_total = 0;

    timer_result_t  step_results[$];
    timer_result_t  due_results[$];
    timer_request_t directed_reqs[$];
    int             mismatches = 0;
    bit             calm = 1'b0;
    bit             hold_req = 1'b0;

    periodic_job_timer_table DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Build a request; fields are cut to their widths here.
    function automatic timer_request_t make_request(int kind, int iv, int rep, int job,
                                                    int tag, int prio, int secs, bit fixed,
                                                    result_kind_t rk, int a_secs, int a_ms);
        timer_request_t rq;
        rq.kind           = kind[1:0];
        rq.interval_ms    = iv[23:0];
        rq.repeat_count   = rep[15:0];
        rq.job_id         = job[7:0];
        rq.context_tag    = tag[15:0];
        rq.priority_req   = prio[3:0];
        rq.cancel_seconds = secs[14:0];
        rq.fixed_answer   = fixed;
        rq.answer_kind    = rk;
        rq.answer_seconds = a_secs;
        rq.answer_millis  = a_ms;
        return rq;
    endfunction

    // Advance the shadow table by one request and collect the results it causes.
    function automatic void advance_timer_table(input timer_request_t rq);
        int k;
        int j;
        logic [31:0] target;
        step_results.delete();
        case (rq.kind)
            KIND_TICK: begin
                model_millis += MS_PER_TICK;
                phase_ticks++;
                if (phase_ticks >= TICKS_PER_SECOND) begin
                    phase_ticks = 0;
                    model_seconds++;
                end
                tick_total++;
                // Walk the table; spent entries drop out and the rest close up.
                k = 0;
                while (k < job_count) begin
                    if (job_repeats[k] == 0) begin
                        for (j = k; j + 1 < job_count; j++) begin
                            job_period[j]    = job_period[j + 1];
                            job_countdown[j] = job_countdown[j + 1];
                            job_repeats[j]   = job_repeats[j + 1];
                            job_ids[j]       = job_ids[j + 1];
                            job_tags[j]      = job_tags[j + 1];
                            job_prios[j]     = job_prios[j + 1];
                        end
                        job_count--;
                    end else begin
                        job_countdown[k] = job_countdown[k] - 1'b1;
                        if (job_countdown[k] == '0) begin
                            job_countdown[k] = job_period[k];
                            step_results.push_back('{RK_FIRE, job_ids[k], job_tags[k],
                                                     job_prios[k], model_seconds,
                                                     model_millis, 1'b0});
                            if (job_repeats[k] > 0) job_repeats[k]--;
                        end
                        k++;
                    end
                end
                step_results.push_back('{RK_TICK_DONE, 8'd0, 16'd0, 4'd0, model_seconds,
                                         model_millis, 1'b1});
            end
            KIND_SCHED: begin
                if (job_count >= TABLE_DEPTH) begin
                    step_results.push_back('{RK_REJECTED, 8'd0, 16'd0, 4'd0, model_seconds,
                                             model_millis, 1'b1});
                end else begin
                    job_period[job_count]    = rq.interval_ms[23:1];
                    job_countdown[job_count] = rq.interval_ms[23:1];
                    job_repeats[job_count]   = rq.repeat_count;
                    job_ids[job_count]       = rq.job_id;
                    job_tags[job_count]      = rq.context_tag;
                    job_prios[job_count]     = rq.priority_req;
                    job_count++;
                    step_results.push_back('{RK_SCHEDULED, 8'd0, 16'd0, 4'd0, model_seconds,
                                             model_millis, 1'b1});
                end
            end
            KIND_CANCEL: begin
                target = rq.cancel_seconds * TICKS_PER_SECOND;
                for (k = 0; k < job_count; k++) begin
                    if ({9'd0, job_period[k]} == target && job_ids[k] == rq.job_id)
                        job_repeats[k] = '0;
                end
                step_results.push_back('{RK_CANCEL_DONE, 8'd0, 16'd0, 4'd0, model_seconds,
                                         model_millis, 1'b1});
            end
            default: begin
            end
        endcase
    endfunction

    // Random request: mostly ticks, well-formed schedules, cancels mostly aimed at live entries.
    function automatic timer_request_t draw_request();
        timer_request_t rq;
        int cands[$];
        int pick;
        int v;
        int s;
        int k;
        rq = make_request(KIND_TICK, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom, 1'b0, RK_FIRE, 0, 0);
        pick = $urandom_range(99);
        if (pick < 2) begin
            rq.kind = KIND_UNUSED;
        end else if (pick < 12) begin
            rq.kind = KIND_SCHED;
            v = $urandom_range(99);
            if (v < 50) begin
                // Short period, a few firings.
                rq.interval_ms  = 24'($urandom_range(0, 24));
                rq.repeat_count = 16'($urandom_range(1, 12));
                rq.job_id       = 8'($urandom_range(0, 7));
            end else if (v < 65) begin
                // Any period, gone on the next tick.
                rq.repeat_count = '0;
            end else begin
                // Period in whole seconds so that a cancel can reach it.
                s = ($urandom_range(9) == 0) ? $urandom_range(0, 16777) : $urandom_range(0, 3);
                rq.interval_ms = 24'(s * 1000 + $urandom_range(0, 1));
                if ($urandom_range(1) == 0) rq.job_id = 8'($urandom_range(0, 7));
            end
        end else if (pick < 17) begin
            rq.kind = KIND_CANCEL;
            for (k = 0; k < job_count; k++) begin
                if (job_period[k] % TICKS_PER_SECOND == 0) cands.push_back(k);
            end
            if (cands.size() > 0 && $urandom_range(3) != 0) begin
                k = cands[$urandom_range(cands.size() - 1)];
                rq.cancel_seconds = 15'(job_period[k] / TICKS_PER_SECOND);
                rq.job_id         = job_ids[k];
            end else if ($urandom_range(1) == 0) begin
                rq.cancel_seconds = 15'($urandom_range(0, 3));
                rq.job_id         = 8'($urandom_range(0, 7));
            end
        end
        return rq;
    endfunction

    // Offer one request, wait for the transaction, and queue what it should produce.
    task automatic present_request(input timer_request_t rq);
        int gap;
        if (!calm && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= rq.kind;
        s_tdata  <= {5'd0, rq.cancel_seconds, rq.priority_req, rq.context_tag, rq.job_id,
                     rq.repeat_count, rq.interval_ms};
        do @(posedge aclk); while (!s_tready);
        advance_timer_table(rq);
        if (rq.fixed_answer) begin
            due_results.push_back('{rq.answer_kind, 8'd0, 16'd0, 4'd0, rq.answer_seconds,
                                    rq.answer_millis, 1'b1});
        end else begin
            foreach (step_results[i]) due_results.push_back(step_results[i]);
        end
    endtask

    // Stop offering, let every result come out, then give the block time to go idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Load the seconds counter while the block is idle.
    task automatic load_start_seconds(input logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_seconds = value;
    endtask

    // Random requests until both the item and the tick counts are met.
    task automatic random_phase(input int min_items, input int min_ticks, input int hold_after);
        int n;
        timer_request_t rq;
        n = 0;
        while (n < min_items || tick_total < min_ticks) begin
            rq = draw_request();
            if (rq.kind != KIND_UNUSED) n++;
            if (n == hold_after) hold_req <= 1'b1;
            present_request(rq);
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Result side: random stalls, one long hold-off, and the field-by-field check.
    initial begin : result_sink
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 22);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        timer_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result transaction: kind %0d", m_tuser);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("result_kind", 32'(want.kind), 32'(m_tuser));
                check_field("fired_job", 32'(want.job), 32'(m_tdata[7:0]));
                check_field("fired_context", 32'(want.tag), 32'(m_tdata[23:8]));
                check_field("fired_priority", 32'(want.prio), 32'(m_tdata[27:24]));
                check_field("seconds_now", want.seconds, m_tdata[59:28]);
                check_field("millis_now", want.millis, m_tdata[91:60]);
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // Main sequence: reset, directed table, random phases, then a run of plain ticks.
    initial begin : stimulus
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows; single-status rows carry their answer, the other ticks go to the shadow table.
        directed_reqs.push_back(make_request(KIND_TICK, 0, 0, 0, 0, 0, 0,
                                             1'b1, RK_TICK_DONE, 0, 2));
        directed_reqs.push_back(make_request(KIND_SCHED, 4, 2, 8'hFF, 16'hFFFF, 4'hF, 0,
                                             1'b1, RK_SCHEDULED, 0, 2));
        // Zero period, repeats forever.
        directed_reqs.push_back(make_request(KIND_SCHED, 0, -1, 0, 0, 0, 0,
                                             1'b1, RK_SCHEDULED, 0, 2));
        // Largest interval, never fires: dropped on the next tick.
        directed_reqs.push_back(make_request(KIND_SCHED, 24'hFFFFFF, 0, 8'h80, 16'h8000, 8,
                                             0, 1'b1, RK_SCHEDULED, 0, 2));
        directed_reqs.push_back(make_request(KIND_SCHED, 16777000, 32767, 1, 1, 1, 0,
                                             1'b1, RK_SCHEDULED, 0, 2));
        directed_reqs.push_back(make_request(KIND_SCHED, 1, -32768, 2, 16'hA5A5, 5, 0,
                                             1'b1, RK_SCHEDULED, 0, 2));
        directed_reqs.push_back(make_request(KIND_SCHED, 3, 3, 3, 16'h5A5A, 4'hA, 0,
                                             1'b1, RK_SCHEDULED, 0, 2));
        directed_reqs.push_back(make_request(KIND_TICK, 0, 0, 0, 0, 0, 0,
                                             1'b0, RK_FIRE, 0, 0));
        directed_reqs.push_back(make_request(KIND_TICK, 0, 0, 0, 0, 0, 0,
                                             1'b0, RK_FIRE, 0, 0));
        directed_reqs.push_back(make_request(KIND_SCHED, 2000, 1, 4, 16'h1234, 2, 0,
                                             1'b1, RK_SCHEDULED, 0, 6));
        directed_reqs.push_back(make_request(KIND_SCHED, 1000, -5, 5, 16'h0F0F, 3, 0,
                                             1'b1, RK_SCHEDULED, 0, 6));
        directed_reqs.push_back(make_request(KIND_SCHED, 2, 1, 6, 16'h00FF, 6, 0,
                                             1'b1, RK_SCHEDULED, 0, 6));
        // Table is full now.
        directed_reqs.push_back(make_request(KIND_SCHED, 2, 1, 7, 16'h7777, 7, 0,
                                             1'b1, RK_REJECTED, 0, 6));
        directed_reqs.push_back(make_request(KIND_TICK, 0, 0, 0, 0, 0, 0,
                                             1'b0, RK_FIRE, 0, 0));
        directed_reqs.push_back(make_request(KIND_TICK, 0, 0, 0, 0, 0, 0,
                                             1'b0, RK_FIRE, 0, 0));
        directed_reqs.push_back(make_request(KIND_CANCEL, 0, 0, 0, 0, 0, 0,
                                             1'b1, RK_CANCEL_DONE, 0, 10));
        directed_reqs.push_back(make_request(KIND_CANCEL, 0, 0, 2, 0, 0, 0,
                                             1'b1, RK_CANCEL_DONE, 0, 10));
        directed_reqs.push_back(make_request(KIND_CANCEL, 0, 0, 8'hFF, 0, 0, 32767,
                                             1'b1, RK_CANCEL_DONE, 0, 10));
        directed_reqs.push_back(make_request(KIND_CANCEL, 0, 0, 1, 0, 0, 16777,
                                             1'b1, RK_CANCEL_DONE, 0, 10));
        directed_reqs.push_back(make_request(KIND_CANCEL, 0, 0, 5, 0, 0, 1,
                                             1'b1, RK_CANCEL_DONE, 0, 10));
        // Unknown kind: no result at all.
        directed_reqs.push_back(make_request(KIND_UNUSED, 24'hFFFFFF, -1, 8'hFF, 16'hFFFF,
                                             4'hF, 15'h7FFF, 1'b0, RK_FIRE, 0, 0));
        directed_reqs.push_back(make_request(KIND_TICK, 0, 0, 0, 0, 0, 0,
                                             1'b0, RK_FIRE, 0, 0));
        directed_reqs.push_back(make_request(KIND_TICK, 0, 0, 0, 0, 0, 0,
                                             1'b0, RK_FIRE, 0, 0));
        foreach (directed_reqs[i]) present_request(directed_reqs[i]);

        // No idling on either side for the whole first phase.
        load_start_seconds(32'h8000_0001);
        calm <= 1'b1;
        random_phase(60, 0, -1);

        // Idling on both sides, with one long hold-off on the result side.
        load_start_seconds(32'h0000_0000);
        calm <= 1'b0;
        random_phase(70, 0, 25);

        // Top of range: the seconds counter wraps when a full second of ticks completes.
        load_start_seconds(32'hFFFF_FFFF);
        random_phase(20, 0, -1);
        while (tick_total < 502) begin
            present_request(make_request(KIND_TICK, 0, 0, 0, 0, 0, 0,
                                         1'b0, RK_FIRE, 0, 0));
        end

        drain();
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard limit on the run.
    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
